// ----- rtl/avtc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// avtc_pkg: shared types and constants of the voltage table controller
// Request and response payloads, configuration bundle, sequencer states,
// shared arithmetic unit opcodes and the status and request codes.
// ============================================================================
package avtc_pkg;

  localparam int DEF_TEMP_REGIONS = 16;
  localparam int DEF_MAX_LEVELS   = 32;

  localparam int VOLT_W  = 12;
  localparam int STEP_W  = 8;
  localparam int LCNT_W  = 6;
  localparam int LVL_W   = 5;
  localparam int REGN_W  = 4;
  localparam int DSTAT_W = 32;
  localparam int ALU_W   = VOLT_W + 1;
  localparam int CFG_IDX_W = 2;

  // request types
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_NOTICE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_DELAY_ERR = 2'd2;
  localparam logic [1:0] STATUS_AT_MAX    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VMIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VSTEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LCOUNT = 2'd3;

  localparam logic [VOLT_W-1:0] VMIN_RESET   = 12'd950;
  localparam logic [VOLT_W-1:0] VMAX_RESET   = 12'd1300;
  localparam logic [STEP_W-1:0] VSTEP_RESET  = 8'd25;
  localparam logic [LCNT_W-1:0] LCOUNT_RESET = 6'd32;

  // delay-circuit status bit positions
  localparam int UP_CPU_BIT = 24;
  localparam int UP_VU_BIT  = 29;
  localparam int UP_L2_BIT  = 30;
  localparam int DN_CPU_BIT = 16;
  localparam int DN_VU_BIT  = 21;
  localparam int DN_L2_BIT  = 22;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [LVL_W-1:0]   level_index;
    logic               begin_flag;
    logic [VOLT_W-1:0]  load_voltage;
    logic [REGN_W-1:0]  temp_region;
    logic [DSTAT_W-1:0] delay_status;
  } req_t;

  typedef struct packed {
    logic              drive_valid;
    logic [VOLT_W-1:0] drive_voltage;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [VOLT_W-1:0] mv_floor;
    logic [VOLT_W-1:0] mv_ceiling;
    logic [STEP_W-1:0] mv_step;
    logic [LCNT_W-1:0] level_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD_WR,
    ST_RAISE_SAT,
    ST_RAISE_CHK,
    ST_RAISE_WR,
    ST_DN_RD,
    ST_DN_CHK_MIN,
    ST_DN_CHK_HERE,
    ST_DN_WR,
    ST_CLAMP_RD,
    ST_CLAMP_CMP,
    ST_FINAL_RD,
    ST_DRIVE,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;
    logic             eq;
  } alu_res_t;

endpackage

// ----- rtl/avtc_table.sv -----
`timescale 1ns / 1ps
// ============================================================================
// avtc_table: voltage table memory
// Single-port array, one write or one read per cycle, registered read data.
// ============================================================================
module avtc_table #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [avtc_pkg::VOLT_W-1:0] wdata,
  output logic [avtc_pkg::VOLT_W-1:0] rdata
);
  import avtc_pkg::*;

  logic [VOLT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/avtc_alu.sv -----
`timescale 1ns / 1ps
// ============================================================================
// avtc_alu: shared add, subtract and compare unit
// A subtractor serves every difference and magnitude compare; a separate adder serves every sum.
// ============================================================================
module avtc_alu (
  input  logic [avtc_pkg::ALU_W-1:0] a,
  input  logic [avtc_pkg::ALU_W-1:0] b,
  input  avtc_pkg::alu_op_t          op,
  output avtc_pkg::alu_res_t         res
);
  import avtc_pkg::*;

  logic [ALU_W:0] diff;
  logic [ALU_W-1:0] sum;

  assign diff = {1'b0, a} - {1'b0, b};
  assign sum  = a + b;

  always_comb begin
    res.ge  = ~diff[ALU_W];
    res.eq  = (diff == '0);
    res.res = (op == ALU_ADD) ? sum : diff[ALU_W-1:0];
  end

endmodule

// ----- rtl/avtc_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// avtc_ctrl: request sequencer
// Decodes a request and walks the table through the shared unit and memory.
// ============================================================================
module avtc_ctrl #(
  parameter int TEMP_REGIONS = avtc_pkg::DEF_TEMP_REGIONS,
  parameter int MAX_LEVELS   = avtc_pkg::DEF_MAX_LEVELS,
  parameter int ADDR_W       = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  avtc_pkg::req_t              req_data,
  input  avtc_pkg::cfg_t              cfg,
  input  logic                        out_free,
  output logic                        done,
  output avtc_pkg::rsp_t              result,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_addr,
  output logic [avtc_pkg::VOLT_W-1:0] mem_wdata,
  input  logic [avtc_pkg::VOLT_W-1:0] mem_rdata,
  output logic [avtc_pkg::ALU_W-1:0]  alu_a,
  output logic [avtc_pkg::ALU_W-1:0]  alu_b,
  output avtc_pkg::alu_op_t           alu_op,
  input  avtc_pkg::alu_res_t          alu_res
);
  import avtc_pkg::*;

  localparam int CNT_MAX = (TEMP_REGIONS > MAX_LEVELS) ? TEMP_REGIONS : MAX_LEVELS;
  localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int CW      = LCNT_W + 1;

  state_t state, state_next;

  req_t              rq;
  req_t              rq_in;
  logic [CNT_W-1:0]  cnt;
  logic [ALU_W-1:0]  acc;
  logic [VOLT_W-1:0] low;
  logic [LVL_W-1:0]  cur_level;
  logic              level_known;
  logic              change_pending;
  logic [VOLT_W-1:0] applied;
  logic              voltage_known;
  logic [1:0]        status;
  logic              drv_valid;
  logic [VOLT_W-1:0] drv_voltage;

  logic [CW-1:0]     count;
  logic              idx_oor, cur_oor;
  logic              rise, fall;
  logic              pair_bad, up_any, dn_all, tick_live;
  logic              last_region, last_level, last_clamp;
  logic [REGN_W-1:0] region_in;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [REGN_W-1:0] rg,
                                                input logic [CW-1:0] lv);
    return ADDR_W'(32'(rg) * MAX_LEVELS + 32'(lv));
  endfunction

  // decode
  always_comb begin
    count = ({1'b0, cfg.level_count} > CW'(MAX_LEVELS)) ? CW'(MAX_LEVELS)
                                                        : {1'b0, cfg.level_count};
    idx_oor = CW'(rq.level_index) >= count;
    cur_oor = CW'(cur_level) >= count;
    rise = rq.begin_flag && level_known && (rq.level_index > cur_level);
    fall = !rq.begin_flag && (!level_known || (rq.level_index < cur_level));
    pair_bad = (rq.delay_status[UP_CPU_BIT] && rq.delay_status[DN_CPU_BIT]) ||
               (rq.delay_status[UP_VU_BIT]  && rq.delay_status[DN_VU_BIT])  ||
               (rq.delay_status[UP_L2_BIT]  && rq.delay_status[DN_L2_BIT]);
    up_any = rq.delay_status[UP_CPU_BIT] || rq.delay_status[UP_VU_BIT] ||
             rq.delay_status[UP_L2_BIT];
    dn_all = rq.delay_status[DN_CPU_BIT] && rq.delay_status[DN_VU_BIT] &&
             rq.delay_status[DN_L2_BIT];
    tick_live   = !change_pending && level_known;
    last_region = CW'(cnt) == CW'(TEMP_REGIONS - 1);
    last_level  = CW'(cnt) == (count - CW'(1));
    last_clamp  = CW'(cnt) == (CW'(cur_level) - CW'(1));
    region_in   = ({1'b0, req_data.temp_region} >= (REGN_W + 1)'(TEMP_REGIONS))
                  ? REGN_W'(TEMP_REGIONS - 1) : req_data.temp_region;
    rq_in             = req_data;
    rq_in.temp_region = region_in;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (rq.req_type)
          REQ_LOAD:   state_next = idx_oor ? ST_DONE : ST_LOAD_WR;
          REQ_NOTICE: state_next = (!idx_oor && (rise || fall)) ? ST_DRIVE : ST_DONE;
          REQ_TICK: begin
            if (!tick_live || cur_oor) state_next = ST_DONE;
            else if (pair_bad)         state_next = ST_FINAL_RD;
            else if (up_any)           state_next = ST_RAISE_SAT;
            else if (dn_all)           state_next = ST_DN_RD;
            else                       state_next = ST_FINAL_RD;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_LOAD_WR:     if (last_region) state_next = ST_DONE;
      ST_RAISE_SAT:   state_next = ST_RAISE_CHK;
      ST_RAISE_CHK:   state_next = ST_RAISE_WR;
      ST_RAISE_WR:    if (last_level) state_next = ST_FINAL_RD;
      ST_DN_RD:       state_next = ST_DN_CHK_MIN;
      ST_DN_CHK_MIN:  state_next = alu_res.ge ? ST_DN_CHK_HERE : ST_FINAL_RD;
      ST_DN_CHK_HERE: state_next = alu_res.ge ? ST_DN_WR : ST_FINAL_RD;
      ST_DN_WR:       state_next = (cur_level == '0) ? ST_FINAL_RD : ST_CLAMP_RD;
      ST_CLAMP_RD:    state_next = ST_CLAMP_CMP;
      ST_CLAMP_CMP:   state_next = last_clamp ? ST_FINAL_RD : ST_CLAMP_RD;
      ST_FINAL_RD:    state_next = ST_DRIVE;
      ST_DRIVE:       state_next = ST_DONE;
      ST_DONE:        if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = mk_addr(rq.temp_region, CW'(cur_level));
    mem_wdata = acc[VOLT_W-1:0];
    alu_a     = {1'b0, applied};
    alu_b     = ALU_W'(cfg.mv_step);
    alu_op    = ALU_ADD;
    case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_DISPATCH: begin
        mem_re   = (rq.req_type == REQ_NOTICE) && !idx_oor && (rise || fall);
        mem_addr = mk_addr(rq.temp_region, CW'(rq.level_index));
      end
      ST_LOAD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = mk_addr(REGN_W'(cnt), CW'(rq.level_index));
        mem_wdata = rq.load_voltage;
      end
      ST_RAISE_SAT: begin
        alu_a = acc;
        alu_b = {1'b0, cfg.mv_ceiling};
      end
      ST_RAISE_CHK: alu_b = {1'b0, cfg.mv_ceiling};
      ST_RAISE_WR: begin
        mem_we   = 1'b1;
        mem_addr = mk_addr(rq.temp_region, CW'(cnt));
      end
      ST_DN_RD: begin
        mem_re = 1'b1;
        alu_a  = {1'b0, cfg.mv_floor};
      end
      ST_DN_CHK_MIN: alu_b = acc;
      ST_DN_CHK_HERE: begin
        alu_a = {1'b0, mem_rdata};
        alu_b = {1'b0, applied};
      end
      ST_DN_WR: begin
        alu_op    = ALU_SUB;
        mem_we    = 1'b1;
        mem_wdata = alu_res.res[VOLT_W-1:0];
      end
      ST_CLAMP_RD: begin
        mem_re   = 1'b1;
        mem_addr = mk_addr(rq.temp_region, CW'(cnt));
      end
      ST_CLAMP_CMP: begin
        alu_a     = {1'b0, mem_rdata};
        alu_b     = {1'b0, low};
        mem_we    = alu_res.ge && !alu_res.eq;
        mem_addr  = mk_addr(rq.temp_region, CW'(cnt));
        mem_wdata = low;
      end
      ST_FINAL_RD: mem_re = 1'b1;
      ST_DRIVE: begin
        alu_a = {1'b0, mem_rdata};
        alu_b = {1'b0, applied};
      end
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  assign result = '{drive_valid: drv_valid, drive_voltage: drv_voltage, status: status};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level      <= '0;
      level_known    <= 1'b0;
      change_pending <= 1'b0;
      applied        <= '0;
      voltage_known  <= 1'b0;
    end else begin
      if (state == ST_DISPATCH && rq.req_type == REQ_NOTICE && !idx_oor) begin
        change_pending <= rq.begin_flag;
        if (rise || fall) begin
          cur_level   <= rq.level_index;
          level_known <= 1'b1;
        end
      end
      if (state == ST_DRIVE && (!voltage_known || !alu_res.eq)) begin
        applied       <= mem_rdata;
        voltage_known <= 1'b1;
      end
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          rq          <= rq_in;
          status      <= STATUS_OK;
          drv_valid   <= 1'b0;
          drv_voltage <= '0;
        end
      end
      ST_DISPATCH: begin
        cnt <= '0;
        acc <= alu_res.res;
        if (rq.req_type == REQ_LOAD || rq.req_type == REQ_NOTICE) begin
          if (idx_oor) status <= STATUS_RANGE;
        end else if (rq.req_type == REQ_TICK && tick_live) begin
          if (cur_oor)       status <= STATUS_RANGE;
          else if (pair_bad) status <= STATUS_DELAY_ERR;
        end
      end
      ST_LOAD_WR, ST_RAISE_WR: cnt <= cnt + CNT_W'(1);
      ST_RAISE_SAT: begin
        if (alu_res.ge && !alu_res.eq) acc <= {1'b0, cfg.mv_ceiling};
      end
      ST_RAISE_CHK: status <= alu_res.ge ? STATUS_AT_MAX : STATUS_OK;
      ST_DN_RD: acc <= alu_res.res;
      ST_DN_WR: begin
        low <= alu_res.res[VOLT_W-1:0];
        cnt <= '0;
      end
      ST_CLAMP_CMP: cnt <= cnt + CNT_W'(1);
      ST_DRIVE: begin
        if (!voltage_known || !alu_res.eq) begin
          drv_valid   <= 1'b1;
          drv_voltage <= mem_rdata;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/adaptive_voltage_table_controller_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// adaptive_voltage_table_controller_unit: adaptive voltage table controller
// Holds a voltage table of temperature regions by frequency levels, answers
// load, frequency change and timer tick requests with one response each.
// ============================================================================
//
//  channel    | signals                          | handshake
//  -----------+----------------------------------+------------------------
//  request    | req_valid, req_ready, req_data   | valid/ready
//  response   | rsp_valid, rsp_ready, rsp_data   | valid/ready, registered
//  config     | cfg_we, cfg_index, cfg_wdata     | write enable, no wait
//
//  One request at a time; req_ready is high only while the sequencer idles.
//  Load: one table write per region on the single memory port. Notice: at
//  most one table read. Tick: no walk when idle or in error, one write per
//  effective level for a raise, clamping of the lower levels for a lower, the
//  walk set by the one table port and shared adder.
//  Reset is synchronous; the table itself is not cleared and needs loading.
//  A held response stalls only the finish: the next request is taken once
//  the finished one has moved into the response register.
//
module adaptive_voltage_table_controller_unit #(
  parameter int TEMP_REGIONS = avtc_pkg::DEF_TEMP_REGIONS,
  parameter int MAX_LEVELS   = avtc_pkg::DEF_MAX_LEVELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [avtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [avtc_pkg::VOLT_W-1:0]    cfg_wdata,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  avtc_pkg::req_t                 req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output avtc_pkg::rsp_t                 rsp_data
);
  import avtc_pkg::*;

  localparam int DEPTH  = TEMP_REGIONS * MAX_LEVELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  logic              out_free;
  logic              done;
  rsp_t              result;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [VOLT_W-1:0] mem_wdata, mem_rdata;
  logic [ALU_W-1:0]  alu_a, alu_b;
  alu_op_t           alu_op;
  alu_res_t          alu_res;

  // configuration registers; writes must arrive only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mv_floor    <= VMIN_RESET;
      cfg.mv_ceiling  <= VMAX_RESET;
      cfg.mv_step     <= VSTEP_RESET;
      cfg.level_count <= LCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VMIN:   cfg.mv_floor    <= cfg_wdata;
        CFG_VMAX:   cfg.mv_ceiling  <= cfg_wdata;
        CFG_VSTEP:  cfg.mv_step     <= cfg_wdata[STEP_W-1:0];
        CFG_LCOUNT: cfg.level_count <= cfg_wdata[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // response register: hold until taken, load when free or draining
  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      rsp_data <= result;
    end
  end

  avtc_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  avtc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  avtc_ctrl #(
    .TEMP_REGIONS (TEMP_REGIONS),
    .MAX_LEVELS   (MAX_LEVELS),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cfg       (cfg),
    .out_free  (out_free),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_op    (alu_op),
    .alu_res   (alu_res)
  );

endmodule
